[hdl/rht_pkg.sv]
// ----------------------------------------------------------------------------
// rht_pkg
// Shared types, sizes and codes for the reference-counted handle table.
// ----------------------------------------------------------------------------
package rht_pkg;

   // table geometry
   localparam int ENTRIES    = 64;
   localparam int KEY_BITS   = 48;
   localparam int COUNT_BITS = 16;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int FILL_BITS  = $clog2(ENTRIES + 1);

   // operation codes
   localparam logic [2:0] OP_ACQUIRE     = 3'd0;
   localparam logic [2:0] OP_LOOKUP      = 3'd1;
   localparam logic [2:0] OP_REFER_IDX   = 3'd2;
   localparam logic [2:0] OP_REFER_KEY   = 3'd3;
   localparam logic [2:0] OP_RELEASE_IDX = 3'd4;
   localparam logic [2:0] OP_RELEASE_KEY = 3'd5;
   localparam logic [2:0] OP_DESTROY_IDX = 3'd6;
   localparam logic [2:0] OP_DESTROY_KEY = 3'd7;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_IGNORED   = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_SATURATED = 3'd4;

   // request beat
   typedef struct packed {
      logic [2:0]          op;
      logic [KEY_BITS-1:0] key;
      logic [IDX_BITS-1:0] slot;
   } req_type;

   // response beat
   typedef struct packed {
      logic signed [IDX_BITS:0] result_index;
      logic [2:0]               status;
      logic                     free_now;
      logic [KEY_BITS-1:0]      free_key;
      logic [COUNT_BITS-1:0]    count_after;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request
      logic scan_init;  // start scan at top used slot
      logic scan_step;  // step scan pointer down
      logic rd_target;  // read target slot
      logic commit;     // apply update, build response
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic by_key;     // request needs a key search
      logic null_key;   // by-key request with key 0
      logic scan_hit;   // registered compare hit
      logic scan_done;  // last slot compared
   } stat_type;

endpackage

[hdl/rht_if.sv]
// ----------------------------------------------------------------------------
// rht_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface rht_if #(
   parameter type PAYLOAD_TYPE = logic
);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hdl/rht_ctrl.sv]
// ----------------------------------------------------------------------------
// rht_ctrl
// Sequencer: capture, key scan one slot per cycle, target read, commit, send.
// ----------------------------------------------------------------------------
module rht_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rht_pkg::stat_type   stat,
   output rht_pkg::ctrl_type   ctrl
);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SCAN, S_READ, S_COMMIT, S_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      ctrl         = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.by_key && !stat.null_key) begin
               ctrl.scan_init = 1'b1;
               state_in       = S_SCAN;
            end else begin
               ctrl.rd_target = 1'b1;
               state_in       = S_READ;
            end
         end
         S_SCAN: begin
            if (stat.scan_hit || stat.scan_done) begin
               ctrl.rd_target = 1'b1;
               state_in       = S_READ;
            end else begin
               ctrl.scan_step = 1'b1;
            end
         end
         S_READ: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            ctrl.commit  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   // a response is only raised out of commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_COMMIT)
      else $error("response raised outside commit");
   // never accept while a response is pending
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready)
      else $error("accept while response pending");
   // held response stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("response dropped");
`endif

endmodule

[hdl/rht_dp.sv]
// ----------------------------------------------------------------------------
// rht_dp
// Datapath: key and count memories, free stack, scan pointer, update logic.
// ----------------------------------------------------------------------------
module rht_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  rht_pkg::ctrl_type                 ctrl,
   output rht_pkg::stat_type                 stat,
   input  logic [2:0]                        req_op,
   input  logic [rht_pkg::KEY_BITS-1:0]      req_key,
   input  logic [rht_pkg::IDX_BITS-1:0]      req_slot,
   output logic signed [rht_pkg::IDX_BITS:0] rsp_result_index,
   output logic [2:0]                        rsp_status,
   output logic                              rsp_free_now,
   output logic [rht_pkg::KEY_BITS-1:0]      rsp_free_key,
   output logic [rht_pkg::COUNT_BITS-1:0]    rsp_count_after
);

   localparam int ENTRIES    = rht_pkg::ENTRIES;
   localparam int KEY_BITS   = rht_pkg::KEY_BITS;
   localparam int COUNT_BITS = rht_pkg::COUNT_BITS;
   localparam int IW = rht_pkg::IDX_BITS;
   localparam int CW = rht_pkg::FILL_BITS;
   localparam logic [CW-1:0]         ENTRIES_C = CW'(ENTRIES);
   localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

   // memories (undefined until written)
   logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
   logic [COUNT_BITS-1:0] count_mem [ENTRIES];
   logic [IW-1:0]         stack_mem [ENTRIES];

   logic [CW-1:0] used_ff, depth_ff;
   logic [CW-1:0] used_in, depth_in;

   // captured request
   logic [2:0]          op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [IW-1:0]       slot_ff;

   // scan
   logic [IW-1:0]       ptr_ff;
   logic                ptr_last_ff;
   logic [KEY_BITS-1:0] scan_key_ff;
   logic                scan_vld_ff, scan_last_ff;
   logic [IW-1:0]       scan_idx_ff;
   logic                found_ff;
   logic [IW-1:0]       tgt_ff;
   logic                primed_ff;

   // target read
   logic [KEY_BITS-1:0]   tkey_ff;
   logic [COUNT_BITS-1:0] tcnt_ff;
   logic [IW-1:0]         top_ff;

   // response registers
   logic signed [IW:0]    res_ff, res_in;
   logic [2:0]            st_ff, st_in;
   logic                  fnow_ff, fnow_in;
   logic [KEY_BITS-1:0]   fkey_ff, fkey_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;

   // write-back controls
   logic [IW-1:0]         wr_addr;
   logic                  key_we, cnt_we, stk_we;
   logic [KEY_BITS-1:0]   key_wd;
   logic [COUNT_BITS-1:0] cnt_wd;

   logic by_key, by_index, slot_ok, hit;
   assign by_key   = (op_ff == rht_pkg::OP_ACQUIRE) || op_ff[0] || (op_ff == rht_pkg::OP_LOOKUP);
   assign by_index = !by_key;
   assign slot_ok  = (CW'(slot_ff) < used_ff);
   assign hit      = found_ff && primed_ff;

   assign stat.by_key    = by_key;
   assign stat.null_key  = (key_ff == '0);
   assign stat.scan_hit  = scan_vld_ff && (scan_key_ff == key_ff);
   assign stat.scan_done = !scan_vld_ff || scan_last_ff;

   // request capture and scan pointer
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff   <= req_op;
         key_ff  <= req_key;
         slot_ff <= req_slot;
      end
      if (ctrl.scan_init) begin
         scan_vld_ff <= (used_ff != '0);
         ptr_ff      <= IW'(used_ff - 1'b1);
         ptr_last_ff <= (used_ff == CW'(1));
         scan_last_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else if (ctrl.scan_step) begin
         scan_key_ff  <= key_mem[ptr_ff];
         scan_idx_ff  <= ptr_ff;
         scan_last_ff <= ptr_last_ff;
         ptr_ff       <= ptr_ff - 1'b1;
         ptr_last_ff  <= (ptr_ff == IW'(1));
      end
      // first scan cycle only primes the compare register
      if (ctrl.scan_init) scan_key_ff <= '0;
      if (ctrl.rd_target) begin
         found_ff <= stat.scan_hit;
         if (by_key) tgt_ff <= scan_idx_ff;
         else        tgt_ff <= slot_ff;
         top_ff  <= stack_mem[IW'(depth_ff - 1'b1)];
      end
   end

   // primed flag after init: first step loads the first real compare
   always_ff @(posedge clock) begin
      if (reset) primed_ff <= 1'b0;
      else if (ctrl.scan_init) primed_ff <= 1'b0;
      else if (ctrl.scan_step) primed_ff <= 1'b1;
   end

   // target slot read, registered in the cycle after the target is known
   always_ff @(posedge clock) begin
      tkey_ff <= key_mem[tgt_ff];
      tcnt_ff <= count_mem[tgt_ff];
   end

   // commit: next response, fill levels and memory writes
   always_comb begin
      res_in   = '1;
      st_in    = rht_pkg::ST_OK;
      fnow_in  = 1'b0;
      fkey_in  = '0;
      cnt_in   = '0;
      used_in  = used_ff;
      depth_in = depth_ff;
      wr_addr  = tgt_ff;
      key_we   = 1'b0;
      key_wd   = '0;
      cnt_we   = 1'b0;
      cnt_wd   = '0;
      stk_we   = 1'b0;
      if (by_key && key_ff == '0) begin
         st_in = rht_pkg::ST_IGNORED;
      end else if (op_ff == rht_pkg::OP_ACQUIRE && !hit) begin
         // miss: reuse freed slot, append, or report full
         if (depth_ff != '0) begin
            depth_in = depth_ff - 1'b1;
            wr_addr  = top_ff;
            key_we   = 1'b1;
            key_wd   = key_ff;
            cnt_we   = 1'b1;
            cnt_wd   = COUNT_BITS'(1);
            res_in   = {1'b0, top_ff};
            cnt_in   = COUNT_BITS'(1);
         end else if (used_ff < ENTRIES_C) begin
            used_in = used_ff + 1'b1;
            wr_addr = IW'(used_ff);
            key_we  = 1'b1;
            key_wd  = key_ff;
            cnt_we  = 1'b1;
            cnt_wd  = COUNT_BITS'(1);
            res_in  = {1'b0, IW'(used_ff)};
            cnt_in  = COUNT_BITS'(1);
         end else begin
            st_in = rht_pkg::ST_FULL;
         end
      end else if (by_key && !hit) begin
         st_in = rht_pkg::ST_NOT_FOUND;
      end else if (by_index && (!slot_ok || tkey_ff == '0)) begin
         st_in = rht_pkg::ST_IGNORED;
      end else begin
         res_in = {1'b0, tgt_ff};
         if (op_ff == rht_pkg::OP_LOOKUP) begin
            cnt_in = tcnt_ff;
         end else if (op_ff inside {rht_pkg::OP_ACQUIRE, rht_pkg::OP_REFER_IDX,
                                    rht_pkg::OP_REFER_KEY}) begin
            if (tcnt_ff == CNT_MAX) begin
               st_in  = rht_pkg::ST_SATURATED;
               cnt_in = CNT_MAX;
            end else begin
               cnt_we = 1'b1;
               cnt_wd = tcnt_ff + 1'b1;
               cnt_in = tcnt_ff + 1'b1;
            end
         end else if ((op_ff inside {rht_pkg::OP_RELEASE_IDX, rht_pkg::OP_RELEASE_KEY})
                      && tcnt_ff > COUNT_BITS'(1)) begin
            cnt_we = 1'b1;
            cnt_wd = tcnt_ff - 1'b1;
            cnt_in = tcnt_ff - 1'b1;
         end else begin
            // drop slot, push on free stack
            fnow_in = 1'b1;
            fkey_in = tkey_ff;
            key_we  = 1'b1;
            cnt_we  = 1'b1;
            if (depth_ff < ENTRIES_C) begin
               stk_we   = 1'b1;
               depth_in = depth_ff + 1'b1;
            end
         end
      end
   end

   // fill levels
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         depth_ff <= '0;
      end else if (ctrl.commit) begin
         used_ff  <= used_in;
         depth_ff <= depth_in;
      end
   end

   // response registers and write-back
   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         res_ff  <= res_in;
         st_ff   <= st_in;
         fnow_ff <= fnow_in;
         fkey_ff <= fkey_in;
         cnt_ff  <= cnt_in;
         if (key_we) key_mem[wr_addr]   <= key_wd;
         if (cnt_we) count_mem[wr_addr] <= cnt_wd;
         if (stk_we) stack_mem[IW'(depth_ff)] <= tgt_ff;
      end
   end

   assign rsp_result_index = res_ff;
   assign rsp_status       = st_ff;
   assign rsp_free_now     = fnow_ff;
   assign rsp_free_key     = fkey_ff;
   assign rsp_count_after  = cnt_ff;

`ifndef SYNTH
   // fill levels never pass the table size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= ENTRIES_C)
      else $error("slots used overflow");
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= used_ff)
      else $error("free stack deeper than used slots");
   // a freed key is never null
   a_free_key: assert property (@(posedge clock) disable iff (reset)
      $past(ctrl.commit) && fnow_ff |-> fkey_ff != '0)
      else $error("null key freed");
`endif

endmodule

[hdl/refcount_handle_table.sv]
// ----------------------------------------------------------------------------
// refcount_handle_table
// Reference-counted key table with LIFO reuse of freed slots.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (op, key, slot), one beat each; every request
// yields exactly one response beat on rsp (result_index, status, free_now,
// free_key, count_after). One request is in flight at a time: req_ready is
// high only while the block is idle.
// By-index and null-key requests go from accept through decode, target read
// and commit to rsp_valid. By-key requests scan the used slots from the top
// down, one slot per cycle, before the target read, and end the scan early
// on a hit. The block takes no new request until the response beat has been
// taken and it has returned to idle.
// Reset clears the slot and free-stack fill counts; the memories need no
// clearing. If the receiver stalls, the response holds and no new request is
// taken until it is accepted.
// ----------------------------------------------------------------------------
module refcount_handle_table (
   input  logic clock,
   input  logic reset,
   rht_if.sink   req,
   rht_if.source rsp
);

   rht_pkg::ctrl_type ctrl;
   rht_pkg::stat_type stat;

   logic signed [rht_pkg::IDX_BITS:0]  res;
   logic [2:0]                         st;
   logic                               fnow;
   logic [rht_pkg::KEY_BITS-1:0]       fkey;
   logic [rht_pkg::COUNT_BITS-1:0]     cnt;

   rht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   rht_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_op           (req.payload.op),
      .req_key          (req.payload.key),
      .req_slot         (req.payload.slot),
      .rsp_result_index (res),
      .rsp_status       (st),
      .rsp_free_now     (fnow),
      .rsp_free_key     (fkey),
      .rsp_count_after  (cnt)
   );

   assign rsp.payload.result_index = res;
   assign rsp.payload.status       = st;
   assign rsp.payload.free_now     = fnow;
   assign rsp.payload.free_key     = fkey;
   assign rsp.payload.count_after  = cnt;

endmodule

[tb/tb_refcount_handle_table.sv]
// ----------------------------------------------------------------------------
// tb_refcount_handle_table
// Self-checking bench for the reference-counted handle table. A queue-fed
// driver sends request beats under varying idle and stall rates; a predictor
// of the slot table builds the expected response for each accepted request,
// and a monitor compares every response beat field by field.
// ----------------------------------------------------------------------------
module tb_refcount_handle_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int      NSLOT   = rht_pkg::ENTRIES;
   localparam int      POOL_SZ = 96;
   localparam [15:0]   CNT_MAX = 16'hFFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rht_if #(.PAYLOAD_TYPE(rht_pkg::req_type)) req_bus ();
   rht_if #(.PAYLOAD_TYPE(rht_pkg::rsp_type)) rsp_bus ();

   refcount_handle_table i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the table
   logic [47:0] tbl_key [NSLOT];
   logic [15:0] tbl_cnt [NSLOT];
   logic [5:0]  free_lifo [NSLOT];
   int          tbl_used;
   int          lifo_depth;

   rht_pkg::req_type pending_reqs [$];
   rht_pkg::rsp_type expected_rsps [$];
   logic [47:0]      key_pool [POOL_SZ];
   int               idle_pct;
   int               stall_pct;
   int               errors;
   logic             req_fire;

   function automatic int find_slot(logic [47:0] k);
      for (int i = tbl_used - 1; i >= 0; i--)
         if (tbl_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void enqueue_req(rht_pkg::req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   // table update and expected response for one request
   function automatic rht_pkg::rsp_type apply_request(rht_pkg::req_type r);
      rht_pkg::rsp_type e;
      int   idx;
      int   n;
      logic by_idx;
      e = '{result_index: -7'sd1, status: rht_pkg::ST_OK, free_now: 1'b0,
            free_key: '0, count_after: '0};
      idx    = -1;
      by_idx = (r.op >= rht_pkg::OP_REFER_IDX) && !r.op[0];
      if (r.op == rht_pkg::OP_ACQUIRE) begin
         if (r.key == '0) begin
            e.status = rht_pkg::ST_IGNORED;
         end else begin
            idx = find_slot(r.key);
            if (idx >= 0) begin
               if (tbl_cnt[idx] == CNT_MAX) e.status = rht_pkg::ST_SATURATED;
               else tbl_cnt[idx]++;
               e.result_index = 7'(idx);
               e.count_after  = tbl_cnt[idx];
            end else begin
               n = -1;
               if (lifo_depth > 0) begin
                  lifo_depth--;
                  n = int'(free_lifo[lifo_depth]);
               end else if (tbl_used < NSLOT) begin
                  n = tbl_used;
                  tbl_used++;
               end else begin
                  e.status = rht_pkg::ST_FULL;
               end
               if (n >= 0) begin
                  tbl_key[n]     = r.key;
                  tbl_cnt[n]     = 16'd1;
                  e.result_index = 7'(n);
                  e.count_after  = 16'd1;
               end
            end
         end
         return e;
      end
      // resolve target slot
      if (by_idx) begin
         if (int'(r.slot) < tbl_used && tbl_key[r.slot] != '0) idx = int'(r.slot);
         else e.status = rht_pkg::ST_IGNORED;
      end else if (r.key == '0) begin
         e.status = rht_pkg::ST_IGNORED;
      end else begin
         idx = find_slot(r.key);
         if (idx < 0) e.status = rht_pkg::ST_NOT_FOUND;
      end
      if (idx >= 0) begin
         e.result_index = 7'(idx);
         if (r.op == rht_pkg::OP_LOOKUP) begin
            e.count_after = tbl_cnt[idx];
         end else if (r.op <= rht_pkg::OP_REFER_KEY) begin
            if (tbl_cnt[idx] == CNT_MAX) e.status = rht_pkg::ST_SATURATED;
            else tbl_cnt[idx]++;
            e.count_after = tbl_cnt[idx];
         end else if (r.op <= rht_pkg::OP_RELEASE_KEY && tbl_cnt[idx] > 16'd1) begin
            tbl_cnt[idx]--;
            e.count_after = tbl_cnt[idx];
         end else begin
            // drop the slot and hand back its key
            e.free_now   = 1'b1;
            e.free_key   = tbl_key[idx];
            tbl_key[idx] = '0;
            tbl_cnt[idx] = '0;
            if (lifo_depth < NSLOT) begin
               free_lifo[lifo_depth] = 6'(idx);
               lifo_depth++;
            end
         end
      end
      return e;
   endfunction

   // accept: predict at the edge where the request beat is taken
   always @(posedge clock) begin
      req_fire = !reset && req_bus.valid && req_bus.ready;
      if (req_fire)
         expected_rsps.insert(expected_rsps.size(), apply_request(req_bus.payload));
   end

   // request driver, updates on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_bus.valid   <= 1'b1;
            req_bus.payload <= pending_reqs.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   // response monitor
   always @(posedge clock) begin
      rht_pkg::rsp_type got;
      rht_pkg::rsp_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         if (expected_rsps.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat %p", got);
         end else begin
            exp_r = expected_rsps.pop_front();
            if (got.result_index !== exp_r.result_index || got.status !== exp_r.status ||
                got.free_now !== exp_r.free_now || got.free_key !== exp_r.free_key ||
                got.count_after !== exp_r.count_after) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: idx %0d/%0d st %0d/%0d fnow %0b/%0b fkey %h/%h cnt %0d/%0d",
                           exp_r.result_index, got.result_index, exp_r.status, got.status,
                           exp_r.free_now, got.free_now, exp_r.free_key, got.free_key,
                           exp_r.count_after, got.count_after);
            end
         end
      end
   end

   function automatic rht_pkg::req_type mk(logic [2:0] op, logic [47:0] k, logic [5:0] s);
      rht_pkg::req_type r;
      r.op   = op;
      r.key  = k;
      r.slot = s;
      return r;
   endfunction

   function automatic logic [47:0] rand_key();
      return 48'({$urandom, $urandom});
   endfunction

   // mostly pool keys so that hits, drops and reuse happen; some null and wild
   function automatic rht_pkg::req_type rand_req();
      logic [47:0] k;
      int          sel;
      int          w;
      sel = $urandom_range(99);
      if (sel < 4) k = '0;
      else if (sel < 10) k = rand_key();
      else k = key_pool[$urandom_range(POOL_SZ - 1)];
      w = $urandom_range(99);
      return mk(w < 35 ? rht_pkg::OP_ACQUIRE : 3'($urandom_range(1, 7)), k,
                6'($urandom_range(63)));
   endfunction

   task automatic wait_drained();
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_bus.valid);
      repeat (80) @(posedge clock);
   endtask

   // random churn, with bursts that fill the table past full and that empty it again
   task automatic queue_random(int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         if (k < 3) begin
            for (int j = 0; j < POOL_SZ; j++)
               enqueue_req(mk(rht_pkg::OP_ACQUIRE, key_pool[j], 6'd0));
            i += POOL_SZ;
         end else if (k < 5) begin
            for (int j = 0; j < POOL_SZ; j++)
               enqueue_req(mk(rht_pkg::OP_DESTROY_IDX, '0, 6'(j)));
            i += POOL_SZ;
         end else begin
            enqueue_req(rand_req());
         end
      end
   endtask

   initial begin
      errors             = 0;
      idle_pct           = 0;
      stall_pct          = 0;
      tbl_used           = 0;
      lifo_depth         = 0;
      req_fire           = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.payload    = '0;
      rsp_bus.ready      = 1'b0;
      foreach (key_pool[i]) key_pool[i] = rand_key() | 48'h1;
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: null keys, bad indexes, misses, every op, all-ones key
      enqueue_req(mk(rht_pkg::OP_ACQUIRE,     '0,                 6'd0));
      enqueue_req(mk(rht_pkg::OP_LOOKUP,      48'h1,              6'd0));
      enqueue_req(mk(rht_pkg::OP_REFER_IDX,   '0,                 6'd0));
      enqueue_req(mk(rht_pkg::OP_ACQUIRE,     48'hFFFF_FFFF_FFFF, 6'd0));
      enqueue_req(mk(rht_pkg::OP_ACQUIRE,     48'h1,              6'd0));
      enqueue_req(mk(rht_pkg::OP_ACQUIRE,     48'hFFFF_FFFF_FFFF, 6'd0));
      enqueue_req(mk(rht_pkg::OP_LOOKUP,      48'hFFFF_FFFF_FFFF, 6'd0));
      enqueue_req(mk(rht_pkg::OP_LOOKUP,      '0,                 6'd0));
      enqueue_req(mk(rht_pkg::OP_REFER_IDX,   '0,                 6'd1));
      enqueue_req(mk(rht_pkg::OP_REFER_IDX,   '0,                 6'd63));
      enqueue_req(mk(rht_pkg::OP_REFER_KEY,   48'h1,              6'd0));
      enqueue_req(mk(rht_pkg::OP_REFER_KEY,   48'h2,              6'd0));
      enqueue_req(mk(rht_pkg::OP_RELEASE_IDX, '0,                 6'd1));
      enqueue_req(mk(rht_pkg::OP_RELEASE_KEY, 48'hFFFF_FFFF_FFFF, 6'd0));
      enqueue_req(mk(rht_pkg::OP_RELEASE_KEY, 48'hFFFF_FFFF_FFFF, 6'd0));
      enqueue_req(mk(rht_pkg::OP_RELEASE_IDX, '0,                 6'd0));
      enqueue_req(mk(rht_pkg::OP_ACQUIRE,     48'h5555_AAAA_5555, 6'd0));
      enqueue_req(mk(rht_pkg::OP_DESTROY_IDX, '0,                 6'd1));
      enqueue_req(mk(rht_pkg::OP_DESTROY_IDX, '0,                 6'd1));
      enqueue_req(mk(rht_pkg::OP_DESTROY_KEY, 48'h5555_AAAA_5555, 6'd0));
      enqueue_req(mk(rht_pkg::OP_DESTROY_KEY, '0,                 6'd0));
      enqueue_req(mk(rht_pkg::OP_RELEASE_KEY, 48'h2,              6'd0));
      wait_drained();

      // random phases with different idle and stall rates
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = (ph == 1 || ph == 3) ? 71 : 0;
         stall_pct = (ph == 2) ? 71 : (ph == 3) ? 29 : 0;
         if (ph == 3) idle_pct = 29;
         queue_random(382);
         wait_drained();
      end

      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[refcount_handle_table.f]
hdl/rht_pkg.sv
hdl/rht_if.sv
hdl/rht_ctrl.sv
hdl/rht_dp.sv
hdl/refcount_handle_table.sv
tb/tb_refcount_handle_table.sv
